// ===== design/rrle_pkg.sv =====
// ----------------------------------------------------------------------------
// rrle_pkg
// Shared types and constants of the raster RLE scanline decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rrle_pkg;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_BODY = 2'd0,
    OP_PAL  = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  // RLE decode phase
  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_COUNT  = 2'd1,
    PH_VALUE  = 2'd2
  } phase_t;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RLE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 2'd3;

  // Pixel depth codes; anything else is 8-bit indexed
  localparam logic [1:0] MODE_RGB24  = 2'd1;
  localparam logic [1:0] MODE_ARGB32 = 2'd2;

  // Palette geometry
  localparam int PAL_DEPTH = 256;
  localparam int PAL_W     = 24;

  typedef struct packed {
    logic [12:0] image_width;
    logic [1:0]  depth_mode;
    logic        rle_enable;
    logic        rgb_order;
  } cfg_t;

  // Result of the decode stage for one word
  typedef struct packed {
    logic       pix;          // pixel completed
    logic       use_pal;      // color comes from the palette
    logic [7:0] index;        // palette index
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       line_end;
    logic       run_pending;
    logic       proto_err;
  } dec_t;

endpackage

`default_nettype wire

// ===== design/rrle_ram.sv =====
// ----------------------------------------------------------------------------
// rrle_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rrle_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/rrle_decode.sv =====
// ----------------------------------------------------------------------------
// rrle_decode
// RLE expansion, pixel byte assembly, column and pad tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module rrle_decode #(
  parameter int          MAX_WIDTH   = 4096,
  parameter logic [7:0]  ESCAPE_CODE = 8'd128
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire rrle_pkg::op_t op,
  input  wire logic [7:0]    body_byte,
  input  wire rrle_pkg::cfg_t cfg,
  output rrle_pkg::dec_t     dec
);
  import rrle_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  phase_t        phase_r, phase_nxt;
  logic [7:0]    run_left_r, run_left_nxt;
  logic [7:0]    run_value_r, run_value_nxt;
  logic [1:0]    slot_r, slot_nxt;
  logic [23:0]   partial_r, partial_nxt;
  logic [CW-1:0] column_r, column_nxt;
  logic          pad_r, pad_nxt;

  logic          dec_en;
  logic [7:0]    dec_byte;
  logic          err;
  logic [31:0]   wsat;
  logic [WW-1:0] eff_w;
  logic [WW-1:0] col_inc;
  logic [1:0]    need_m1;
  logic [7:0]    b0, b1, b2;

  // Effective width: zero reads as one, saturate at the maximum
  always_comb begin
    if (cfg.image_width == '0) begin
      wsat = 32'd1;
    end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
      wsat = 32'(MAX_WIDTH);
    end else begin
      wsat = 32'(cfg.image_width);
    end
    eff_w = wsat[WW-1:0];
  end

  // RLE front end: picks the decoded byte for this word, if any
  always_comb begin
    phase_nxt     = phase_r;
    run_left_nxt  = run_left_r;
    run_value_nxt = run_value_r;
    dec_en        = 1'b0;
    dec_byte      = body_byte;
    err           = 1'b0;
    case (op)
      OP_BODY: begin
        if (run_left_r != '0) begin
          err = 1'b1;
        end else if (!cfg.rle_enable) begin
          dec_en = 1'b1;
        end else begin
          case (phase_r)
            PH_COUNT: begin
              if (body_byte == '0) begin
                phase_nxt = PH_NORMAL;
                dec_en    = 1'b1;
                dec_byte  = ESCAPE_CODE;
              end else begin
                run_value_nxt = body_byte;
                phase_nxt     = PH_VALUE;
              end
            end
            PH_VALUE: begin
              run_left_nxt  = run_value_r;
              run_value_nxt = body_byte;
              phase_nxt     = PH_NORMAL;
              dec_en        = 1'b1;
            end
            default: begin
              if (body_byte == ESCAPE_CODE) begin
                phase_nxt = PH_COUNT;
              end else begin
                phase_nxt = PH_NORMAL;
                dec_en    = 1'b1;
              end
            end
          endcase
        end
      end
      OP_TICK: begin
        if (run_left_r != '0) begin
          run_left_nxt = run_left_r - 8'd1;
          dec_en       = 1'b1;
          dec_byte     = run_value_r;
        end
      end
      default: ;
    endcase
  end

  // Pixel assembly from decoded bytes
  always_comb begin
    case (cfg.depth_mode)
      MODE_RGB24:  need_m1 = 2'd2;
      MODE_ARGB32: need_m1 = 2'd3;
      default:     need_m1 = 2'd0;
    endcase
    b0      = partial_r[7:0];
    b1      = partial_r[15:8];
    b2      = partial_r[23:16];
    col_inc = WW'(column_r) + WW'(1);

    slot_nxt    = slot_r;
    partial_nxt = partial_r;
    column_nxt  = column_r;
    pad_nxt     = pad_r;
    dec         = '0;
    dec.proto_err   = err;
    dec.run_pending = (run_left_nxt != '0);

    if (dec_en) begin
      if (pad_r) begin
        pad_nxt = 1'b0;
      end else if (slot_r < need_m1) begin
        case (slot_r)
          2'd0:    partial_nxt[7:0]   = dec_byte;
          2'd1:    partial_nxt[15:8]  = dec_byte;
          default: partial_nxt[23:16] = dec_byte;
        endcase
        slot_nxt = slot_r + 2'd1;
      end else begin
        dec.pix   = 1'b1;
        dec.alpha = 8'hFF;
        case (cfg.depth_mode)
          MODE_RGB24: begin
            dec.red   = cfg.rgb_order ? b0 : dec_byte;
            dec.green = b1;
            dec.blue  = cfg.rgb_order ? dec_byte : b0;
          end
          MODE_ARGB32: begin
            dec.alpha = b0;
            dec.red   = cfg.rgb_order ? b1 : dec_byte;
            dec.green = b2;
            dec.blue  = cfg.rgb_order ? dec_byte : b1;
          end
          default: begin
            dec.use_pal = 1'b1;
            dec.index   = dec_byte;
            dec.alpha   = 8'hFF;
          end
        endcase
        slot_nxt    = '0;
        partial_nxt = '0;
        // end of scanline: wrap column, maybe drop a pad byte
        if (col_inc >= eff_w) begin
          column_nxt   = '0;
          dec.line_end = 1'b1;
          pad_nxt      = eff_w[0] && (cfg.depth_mode != MODE_ARGB32);
        end else begin
          column_nxt = col_inc[CW-1:0];
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_NORMAL;
      run_left_r  <= '0;
      run_value_r <= '0;
      slot_r      <= '0;
      partial_r   <= '0;
      column_r    <= '0;
      pad_r       <= 1'b0;
    end else if (en) begin
      phase_r     <= phase_nxt;
      run_left_r  <= run_left_nxt;
      run_value_r <= run_value_nxt;
      slot_r      <= slot_nxt;
      partial_r   <= partial_nxt;
      column_r    <= column_nxt;
      pad_r       <= pad_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/raster_rle_scanline_decoder_top.sv =====
// ----------------------------------------------------------------------------
// raster_rle_scanline_decoder_top
// Streaming raster body decoder: RLE expansion, pixel assembly, palette.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per accepted item (body byte, palette write or tick).
//   out_* : one result word for every input word, in order.
//   cfg_* : register writes, always ready; write only while idle (unchecked).
// Every input word gives exactly one output word. A word is decoded in the
// cycle it is accepted, registered in the palette stage with the palette
// RAM read, then color-selected into the output register. Throughput is one
// word per cycle while the receiver takes results; the palette RAM has a
// separate write and read port, so palette writes and lookups do not
// collide. When the receiver stalls, the output register holds, the palette
// stage holds one more word, and in_stall rises once both are full.
// Reset clears the decode state and the pipeline, sets the registers to
// width 1, 8-bit indexed, RLE off, BGR order, and marks all 256 palette
// entries as unwritten so they read as the gray ramp (no clearing pass).
// ----------------------------------------------------------------------------
`default_nettype none

module raster_rle_scanline_decoder_top #(
  parameter int         MAX_WIDTH   = 4096,
  parameter logic [7:0] ESCAPE_CODE = 8'd128
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        in_opcode,
  input  wire logic [7:0]                        in_body_byte,
  input  wire logic [7:0]                        in_palette_index,
  input  wire logic [7:0]                        in_palette_red,
  input  wire logic [7:0]                        in_palette_green,
  input  wire logic [7:0]                        in_palette_blue,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_pixel_valid,
  output logic [7:0]                             out_red,
  output logic [7:0]                             out_green,
  output logic [7:0]                             out_blue,
  output logic [7:0]                             out_alpha,
  output logic                                   out_line_end,
  output logic                                   out_run_pending,
  output logic                                   out_protocol_error,
  // configuration
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rrle_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rrle_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rrle_pkg::*;

  localparam int PAW = $clog2(PAL_DEPTH);

  cfg_t           cfg_r;
  dec_t           dec;
  dec_t           s1_r;
  logic           s1_valid_r;
  logic           s1_hit_r;
  logic           out_valid_r;
  logic [PAL_DEPTH-1:0] pal_vld_r;
  logic [PAL_W-1:0] pal_q;
  logic           free;
  logic           s1_adv;
  logic           in_accept;
  logic           pal_we;
  logic           pal_re;
  logic [7:0]     s1_red, s1_green, s1_blue;
  logic           out_pix_r, out_le_r, out_rp_r, out_err_r;
  logic [7:0]     out_red_r, out_green_r, out_blue_r, out_alpha_r;

  // Handshake: output register frees when empty or taken
  assign free      = !out_valid_r || !out_stall;
  assign s1_adv    = !s1_valid_r || free;
  assign in_stall  = !s1_adv;
  assign in_accept = in_valid && s1_adv;
  assign cfg_ready = 1'b1;

  assign pal_we = in_accept && (op_t'(in_opcode) == OP_PAL);
  assign pal_re = in_accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width <= 13'd1;
      cfg_r.depth_mode  <= '0;
      cfg_r.rle_enable  <= 1'b0;
      cfg_r.rgb_order   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WIDTH: cfg_r.image_width <= cfg_data;
        CFG_DEPTH: cfg_r.depth_mode  <= cfg_data[1:0];
        CFG_RLE:   cfg_r.rle_enable  <= cfg_data[0];
        CFG_ORDER: cfg_r.rgb_order   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Decode stage
  rrle_decode #(
    .MAX_WIDTH   (MAX_WIDTH),
    .ESCAPE_CODE (ESCAPE_CODE)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (in_accept),
    .op        (op_t'(in_opcode)),
    .body_byte (in_body_byte),
    .cfg       (cfg_r),
    .dec       (dec)
  );

  // Palette memory; unwritten entries fall back to the gray ramp
  rrle_ram #(
    .WIDTH (PAL_W),
    .DEPTH (PAL_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_palette_index[PAW-1:0]),
    .wdata ({in_palette_red, in_palette_green, in_palette_blue}),
    .re    (pal_re),
    .raddr (dec.index[PAW-1:0]),
    .rdata (pal_q)
  );

  // Control: valid bits and pipeline occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_vld_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pal_we) begin
        pal_vld_r[in_palette_index[PAW-1:0]] <= 1'b1;
      end
      if (s1_adv) begin
        s1_valid_r <= in_accept;
      end
      if (free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Palette stage payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r     <= dec;
      s1_hit_r <= pal_vld_r[dec.index[PAW-1:0]];
    end
  end

  // Color select after the RAM read
  always_comb begin
    s1_red   = s1_r.red;
    s1_green = s1_r.green;
    s1_blue  = s1_r.blue;
    if (s1_r.use_pal) begin
      if (s1_hit_r) begin
        s1_red   = pal_q[23:16];
        s1_green = pal_q[15:8];
        s1_blue  = pal_q[7:0];
      end else begin
        s1_red   = s1_r.index;
        s1_green = s1_r.index;
        s1_blue  = s1_r.index;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (free && s1_valid_r) begin
      out_pix_r   <= s1_r.pix;
      out_red_r   <= s1_red;
      out_green_r <= s1_green;
      out_blue_r  <= s1_blue;
      out_alpha_r <= s1_r.alpha;
      out_le_r    <= s1_r.line_end;
      out_rp_r    <= s1_r.run_pending;
      out_err_r   <= s1_r.proto_err;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pixel_valid    = out_pix_r;
  assign out_red            = out_red_r;
  assign out_green          = out_green_r;
  assign out_blue           = out_blue_r;
  assign out_alpha          = out_alpha_r;
  assign out_line_end       = out_le_r;
  assign out_run_pending    = out_rp_r;
  assign out_protocol_error = out_err_r;

  // Checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with room in the pipeline");

  a_err_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_r.proto_err |-> !s1_r.pix)
    else $error("protocol error word carries a pixel");

  a_no_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_pix_r |->
      (out_red_r == '0) && (out_alpha_r == '0) && !out_le_r)
    else $error("empty result word carries pixel data");

  a_pal_mark: assert property (@(posedge clk) disable iff (!rst_n)
    pal_we |=> pal_vld_r[$past(in_palette_index[PAW-1:0])])
    else $error("palette write did not mark its entry");

endmodule

`default_nettype wire
